### hdl/dia_pkg.sv
// dia_pkg: shared widths, command and status codes for the dedup index assigner
// no dependencies; compiled first
package dia_pkg;

  localparam int ENTRIES_DEF   = 1024;
  localparam int KEY_WIDTH_DEF = 64;

  localparam int CMD_W    = 2;
  localparam int KEY_IN_W = 64;
  localparam int IDX_W    = 10;
  localparam int CNT_W    = 11;
  localparam int ST_W     = 2;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMAP  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic done;
    logic hit;
  } srch_stat_t;

endpackage

### hdl/dia_if.sv
// dia_in_if / dia_out_if: valid-ready request and result channels of the dedup index assigner
// depends on dia_pkg
interface dia_in_if;
  import dia_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [KEY_IN_W-1:0] key;
  logic [IDX_W-1:0]    old_index;

  modport source (output valid, cmd, key, old_index, input ready);
  modport sink   (input valid, cmd, key, old_index, output ready);
endinterface

interface dia_out_if;
  import dia_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] new_index;
  logic             duplicate;
  logic [CNT_W-1:0] unique_count;
  logic [ST_W-1:0]  status;

  modport source (output valid, new_index, duplicate, unique_count, status, input ready);
  modport sink   (input valid, new_index, duplicate, unique_count, status, output ready);
endinterface

### hdl/dia_key_store.sv
// dia_key_store: unique key memory with one shared comparator scanning an entry a cycle
// depends on dia_pkg
module dia_key_store #(
  parameter int ENTRIES   = dia_pkg::ENTRIES_DEF,
  parameter int KEY_WIDTH = dia_pkg::KEY_WIDTH_DEF,
  localparam int AW = $clog2(ENTRIES),
  localparam int CW = $clog2(ENTRIES + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start_i,
  input  logic [KEY_WIDTH-1:0] key_i,
  input  logic [CW-1:0]        total_i,
  input  logic                 append_i,
  input  logic [AW-1:0]        append_addr_i,
  output dia_pkg::srch_stat_t  stat_o,
  output logic [AW-1:0]        hit_idx_o
);
  import dia_pkg::*;

  logic [KEY_WIDTH-1:0] mem [ENTRIES];
  logic [KEY_WIDTH-1:0] key_r;
  logic [KEY_WIDTH-1:0] rd_data_r;
  logic [CW-1:0]        scan_r;
  logic [AW-1:0]        pend_idx_r;
  logic                 pend_r;
  logic                 busy_r;
  logic                 issue;
  logic                 match;

  assign issue     = busy_r && (scan_r < total_i);
  assign match     = busy_r && pend_r && (rd_data_r == key_r);
  assign hit_idx_o = pend_idx_r;

  always_comb begin
    stat_o.hit  = match;
    stat_o.done = match || (busy_r && !issue && !pend_r);
  end

  // key memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (append_i) begin
      mem[append_addr_i] <= key_r;
    end
    if (issue) begin
      rd_data_r <= mem[scan_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      scan_r <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      pend_r <= 1'b0;
      scan_r <= '0;
      key_r  <= key_i;
    end else if (busy_r) begin
      if (stat_o.done) begin
        busy_r <= 1'b0;
        pend_r <= 1'b0;
      end else begin
        pend_r <= issue;
        if (issue) begin
          pend_idx_r <= scan_r[AW-1:0];
          scan_r     <= scan_r + CW'(1);
        end
      end
    end
  end

endmodule

### hdl/dia_map_store.sv
// dia_map_store: old-to-new index memory, one write and one registered read port
// depends on dia_pkg for default sizes
module dia_map_store #(
  parameter int ENTRIES = dia_pkg::ENTRIES_DEF,
  localparam int AW = $clog2(ENTRIES)
) (
  input  logic          clk,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [AW-1:0] wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [AW-1:0] rd_data_o
);
  import dia_pkg::*;

  logic [AW-1:0] mem [ENTRIES];
  logic [AW-1:0] rd_data_r;

  assign rd_data_o = rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_r <= mem[rd_addr_i];
    end
  end

endmodule

### hdl/dedup_index_assign_remap_core.sv
// dedup_index_assign_remap_core: insert with dedup, remap old index, clear
// throughput: one request at a time; the insert scan is bound by the key memory read port,
//   one stored key compared per cycle through a single comparator
// a new request is taken while the previous result still waits in the output register
// reset (rst_n, synchronous): counts cleared, memories keep contents, no clearing pass
module dedup_index_assign_remap_core #(
  parameter int ENTRIES   = dia_pkg::ENTRIES_DEF,
  parameter int KEY_WIDTH = dia_pkg::KEY_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  dia_in_if.sink     in_ch,
  dia_out_if.source  out_ch
);
  import dia_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  // common width for comparing the external old index with the item count
  localparam int WW = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_MAPRD, S_FINISH} state_t;

  state_t           state_r;
  logic [CW-1:0]    item_cnt_r;   // items inserted since clear
  logic [CW-1:0]    uniq_r;       // unique keys since clear
  logic [IDX_W-1:0] res_idx_r;
  logic             res_dup_r;
  logic [ST_W-1:0]  res_st_r;
  logic             out_valid_r;
  logic [IDX_W-1:0] out_idx_r;
  logic             out_dup_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic [ST_W-1:0]  out_st_r;

  logic          accept;
  logic          full;
  logic          in_range;
  logic          start;
  logic          map_rd;
  logic          map_wr;
  logic          append;
  logic          out_free;
  logic [AW-1:0] map_wr_data;
  logic [AW-1:0] map_rd_data;
  logic [AW-1:0] hit_idx;
  srch_stat_t    srch;

  // handshake
  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.new_index    = out_idx_r;
  assign out_ch.duplicate    = out_dup_r;
  assign out_ch.unique_count = out_cnt_r;
  assign out_ch.status       = out_st_r;

  // table full once every item slot has been used
  assign full     = (item_cnt_r == CW'(ENTRIES));
  assign in_range = WW'(in_ch.old_index) < WW'(item_cnt_r);

  assign start  = accept && (in_ch.cmd == CMD_INSERT) && !full;
  assign map_rd = accept && (in_ch.cmd == CMD_REMAP) && in_range;

  // search end: record mapping, append key on a miss
  assign map_wr      = (state_r == S_SEARCH) && srch.done;
  assign map_wr_data = srch.hit ? hit_idx : uniq_r[AW-1:0];
  assign append      = map_wr && !srch.hit;

  dia_key_store #(
    .ENTRIES   (ENTRIES),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_key_store (
    .clk           (clk),
    .rst_n         (rst_n),
    .start_i       (start),
    .key_i         (in_ch.key[KEY_WIDTH-1:0]),
    .total_i       (uniq_r),
    .append_i      (append),
    .append_addr_i (uniq_r[AW-1:0]),
    .stat_o        (srch),
    .hit_idx_o     (hit_idx)
  );

  dia_map_store #(
    .ENTRIES (ENTRIES)
  ) u_map_store (
    .clk       (clk),
    .wr_en_i   (map_wr),
    .wr_addr_i (item_cnt_r[AW-1:0]),
    .wr_data_i (map_wr_data),
    .rd_en_i   (map_rd),
    .rd_addr_i (AW'(in_ch.old_index)),
    .rd_data_o (map_rd_data)
  );

  // sequencer with result and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      item_cnt_r  <= '0;
      uniq_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // the finish state does its own handoff of the output register
      if (out_valid_r && out_ch.ready && state_r != S_FINISH) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            res_idx_r <= '0;
            res_dup_r <= 1'b0;
            res_st_r  <= ST_OK;
            unique case (in_ch.cmd)
              CMD_CLEAR: begin
                item_cnt_r <= '0;
                uniq_r     <= '0;
                state_r    <= S_FINISH;
              end
              CMD_INSERT: begin
                if (full) begin
                  res_st_r <= ST_FULL;
                  state_r  <= S_FINISH;
                end else begin
                  state_r <= S_SEARCH;
                end
              end
              CMD_REMAP: begin
                if (in_range) begin
                  state_r <= S_MAPRD;
                end else begin
                  res_st_r <= ST_RANGE;
                  state_r  <= S_FINISH;
                end
              end
              default: begin
                // unused command: counts unchanged, an OK result is returned
                state_r <= S_FINISH;
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (srch.done) begin
            item_cnt_r <= item_cnt_r + CW'(1);
            if (!srch.hit) begin
              uniq_r <= uniq_r + CW'(1);
            end
            res_idx_r <= IDX_W'(map_wr_data);
            res_dup_r <= srch.hit;
            state_r   <= S_FINISH;
          end
        end
        S_MAPRD: begin
          res_idx_r <= IDX_W'(map_rd_data);
          state_r   <= S_FINISH;
        end
        S_FINISH: begin
          // wait for the output register to free up
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_idx_r   <= res_idx_r;
            out_dup_r   <= res_dup_r;
            out_cnt_r   <= CNT_W'(uniq_r);
            out_st_r    <= res_st_r;
            state_r     <= S_IDLE;
          end
        end
      endcase
    end
  end

  // unique keys never outnumber inserted items
  a_uniq_le_items: assert property (@(posedge clk) disable iff (!rst_n)
    uniq_r <= item_cnt_r)
    else $error("unique count above item count");

  a_items_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    item_cnt_r <= CW'(ENTRIES))
    else $error("item count above table size");

  a_done_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    srch.done |-> state_r == S_SEARCH)
    else $error("search finished outside search state");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.cmd == CMD_CLEAR |=> item_cnt_r == '0 && uniq_r == '0)
    else $error("clear did not empty tables");

  a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SEARCH && srch.done |=> item_cnt_r == $past(item_cnt_r) + CW'(1))
    else $error("insert did not advance item count");

endmodule
